@@ design/bhsh_pkg.sv @@
// Package: shared constants, types and functions of the box hit source histogram.
`default_nettype none
package bhsh_pkg;

  // Block dimensions
  localparam int SENSORS     = 4;
  localparam int SOURCES     = 256;
  localparam int NUM_CENTERS = 4;
  localparam int COORD_W     = 21;
  localparam int CFG_W       = 3 * COORD_W;
  localparam int ID_W        = 24;
  localparam int FUNC_W      = 2;
  localparam int SEL_W       = 2;
  localparam int SRC_W       = 8;
  localparam int CNT_W       = 32;
  localparam int USED_W      = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int ROW_W       = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int ROW_DATA_W  = SENSORS * CNT_W;

  // Identifier to bin: id / 10000 = (id >> 4) / 625, done as a reciprocal
  // multiply that is exact for every 20-bit quotient input.
  localparam int              DIV_PRE   = 4;
  localparam int              DIV_IN_W  = ID_W - DIV_PRE;
  localparam int              DIV_SHIFT = 29;
  localparam logic [19:0]     DIV_MUL   = 20'd858994;
  localparam int              PROD_W    = DIV_IN_W + 20;
  localparam int              Q_W       = PROD_W - DIV_SHIFT;

  localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};
  localparam logic [USED_W-1:0] USED_RESET = USED_W'(4);

  // Function codes
  typedef enum logic [FUNC_W-1:0] {
    FN_ADD    = 2'd0,
    FN_RD_BIN = 2'd1,
    FN_RD_TOT = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_SIZE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SENSORS_USED = 3'd5;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [NUM_CENTERS-1:0][CFG_W-1:0] center;
    logic [CFG_W-1:0]                  box_size;
    logic [USED_W-1:0]                 sensors_used;
  } cfg_t;

  // One input item
  typedef struct packed {
    func_t                      func;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic signed [COORD_W-1:0]  pos_z;
    logic [ID_W-1:0]            particle_id;
    logic [SEL_W-1:0]           sensor_sel;
    logic [SRC_W-1:0]           source_sel;
  } item_t;

  // Classified item handed to the update stage
  typedef struct packed {
    func_t              func;
    logic [SENSORS-1:0] hit;
    logic               id_valid;
    logic [SRC_W-1:0]   src_index;
    logic [ROW_W-1:0]   row;
    logic [SEL_W-1:0]   sensor_sel;
    logic [SRC_W-1:0]   source_sel;
  } cls_t;

  // Saturating increment of a count
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage
`default_nettype wire

@@ design/bhsh_if.sv @@
// Interfaces: particle input channel, result channel and configuration write channel.
`default_nettype none
interface bhsh_in_if
  import bhsh_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic [ID_W-1:0]           particle_id;
  logic [SEL_W-1:0]          sensor_sel;
  logic [SRC_W-1:0]          source_sel;

  modport source (output valid, func, pos_x, pos_y, pos_z, particle_id, sensor_sel,
                  source_sel, input ready);
  modport sink (input valid, func, pos_x, pos_y, pos_z, particle_id, sensor_sel,
                source_sel, output ready);
endinterface

interface bhsh_out_if
  import bhsh_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [SENSORS-1:0] hit_mask;
  logic [SRC_W-1:0]   source_index;
  logic               id_valid;
  logic [CNT_W-1:0]   read_value;

  modport source (output valid, hit_mask, source_index, id_valid, read_value, input ready);
  modport sink (input valid, hit_mask, source_index, id_valid, read_value, output ready);
endinterface

interface bhsh_cfg_if
  import bhsh_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/bhsh_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bhsh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ design/bhsh_cfg.sv @@
// Configuration register file: sensor centers, box size and enabled sensor count.
`default_nettype none
module bhsh_cfg
  import bhsh_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  bhsh_cfg_if.sink  cfg_ch,
  output cfg_t      cfg
);

  cfg_t cfg_r;
  logic wr_en;

  // Always take a write transaction
  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid;

  // Store the addressed register; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center       <= '0;
      cfg_r.box_size     <= '0;
      cfg_r.sensors_used <= USED_RESET;
    end else if (wr_en) begin
      case (cfg_ch.index)
        REG_CENTER_0:     cfg_r.center[0]    <= cfg_ch.data;
        REG_CENTER_1:     cfg_r.center[1]    <= cfg_ch.data;
        REG_CENTER_2:     cfg_r.center[2]    <= cfg_ch.data;
        REG_CENTER_3:     cfg_r.center[3]    <= cfg_ch.data;
        REG_BOX_SIZE:     cfg_r.box_size     <= cfg_ch.data;
        REG_SENSORS_USED: cfg_r.sensors_used <= cfg_ch.data[USED_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

@@ design/bhsh_classify.sv @@
// Item classifier: maps the identifier to a source bin and tests the sensor boxes.
`default_nettype none
module bhsh_classify
  import bhsh_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  load,
  input  wire logic  map_en,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output cls_t       cls
);

  item_t              item_r;
  logic [Q_W-1:0]     q_r;
  logic [Q_W-1:0]     q_nxt;
  logic [SENSORS-1:0] hit_raw_r;
  logic [SENSORS-1:0] hit_raw_nxt;
  logic [PROD_W-1:0]  prod;
  logic               id_valid;
  logic [Q_W-1:0]     bin;

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item;
    end
  end

  // Divide the identifier by 10000 through a reciprocal multiply
  assign prod  = PROD_W'(item_r.particle_id[ID_W-1:DIV_PRE]) * PROD_W'(DIV_MUL);
  assign q_nxt = prod[PROD_W-1:DIV_SHIFT];

  // Test each enabled box on all three axes: -s <= 2*(p - c) <= s
  always_comb begin
    logic signed [COORD_W-1:0] p [3];
    logic signed [COORD_W-1:0] c;
    logic signed [COORD_W+2:0] d;
    logic signed [COORD_W+2:0] s;
    logic                      in_box;
    p[0] = item_r.pos_x;
    p[1] = item_r.pos_y;
    p[2] = item_r.pos_z;
    for (int i = 0; i < SENSORS; i++) begin
      in_box = (i < NUM_CENTERS) && (i < int'(cfg.sensors_used));
      for (int k = 0; k < 3; k++) begin
        c = (i < NUM_CENTERS) ? cfg.center[i % NUM_CENTERS][k*COORD_W +: COORD_W] : '0;
        s = $signed({3'b000, cfg.box_size[k*COORD_W +: COORD_W]});
        d = ((COORD_W+3)'(p[k]) - (COORD_W+3)'(c)) <<< 1;
        if (!((d >= -s) && (d <= s))) begin
          in_box = 1'b0;
        end
      end
      hit_raw_nxt[i] = in_box;
    end
  end

  // Register the quotient and raw hits
  always_ff @(posedge clk) begin
    if (map_en) begin
      q_r       <= q_nxt;
      hit_raw_r <= hit_raw_nxt;
    end
  end

  // Bin is quotient minus one; valid only inside the source range
  assign id_valid = (q_r != '0) && (int'(q_r) <= SOURCES);
  assign bin      = q_r - Q_W'(1);

  always_comb begin
    cls.func       = item_r.func;
    cls.id_valid   = (item_r.func == FN_ADD) && id_valid;
    cls.hit        = hit_raw_r & {SENSORS{cls.id_valid}};
    cls.src_index  = cls.id_valid ? SRC_W'(bin) : '0;
    cls.row        = ROW_W'(bin);
    cls.sensor_sel = item_r.sensor_sel;
    cls.source_sel = item_r.source_sel;
  end

endmodule
`default_nettype wire

@@ design/box_hit_source_histogram_top.sv @@
// Top level: per-sensor source histogram with box hit test and count readout.
//
// Channels: in_ch takes items (add particle, read bin count, read sensor
// total), out_ch returns one result per item, cfg_ch writes the center,
// box size and sensors_used registers (always ready, one write a cycle).
// All channels move a transaction at a clock edge with valid and ready high.
// Each item has four steps: accept, bin map and box test, count memory read,
// then write back and result load, which waits while the output register is
// full. out_ch.valid rises as the result loads, in_ch.ready with it; items
// are taken one at a time. The steps follow the read-modify-write of the
// count memory, one row per source bin holding all sensor counts, with a
// registered read. Reset (rst_n low, synchronous) clears the sensor totals
// and starts a clearing pass over the 256 count memory rows; in_ch.ready
// stays low during that pass, configuration writes are still taken.
// When the receiver stalls, the result holds in the output register; one
// more item is accepted and worked on, then waits before write back until
// the output register is free.
`default_nettype none
module box_hit_source_histogram_top
  import bhsh_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  bhsh_in_if.sink    in_ch,
  bhsh_out_if.source out_ch,
  bhsh_cfg_if.sink   cfg_ch
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MAP   = 5'b00100,
    ST_READ  = 5'b01000,
    ST_UPD   = 5'b10000
  } state_t;

  state_t                  state_r;
  state_t                  state_nxt;
  logic [ROW_W-1:0]        clr_addr_r;
  cfg_t                    cfg;
  item_t                   item;
  cls_t                    cls;
  logic                    in_acc;
  logic                    out_free;
  logic                    upd_go;
  logic                    is_add;
  logic                    ram_we;
  logic                    ram_re;
  logic [ROW_W-1:0]        ram_waddr;
  logic [ROW_W-1:0]        ram_raddr;
  logic [ROW_DATA_W-1:0]   ram_wdata;
  logic [ROW_DATA_W-1:0]   ram_rdata;
  logic [ROW_DATA_W-1:0]   new_row;
  logic [CNT_W-1:0]        tot_r [SENSORS];
  logic [CNT_W-1:0]        rd_value;
  logic                    out_valid_r;
  logic [SENSORS-1:0]      out_hit_r;
  logic [SRC_W-1:0]        out_src_r;
  logic                    out_idv_r;
  logic [CNT_W-1:0]        out_rd_r;

  bhsh_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Pack the input transaction
  always_comb begin
    item.func        = func_t'(in_ch.func);
    item.pos_x       = in_ch.pos_x;
    item.pos_y       = in_ch.pos_y;
    item.pos_z       = in_ch.pos_z;
    item.particle_id = in_ch.particle_id;
    item.sensor_sel  = in_ch.sensor_sel;
    item.source_sel  = in_ch.source_sel;
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  bhsh_classify u_classify (
    .clk    (clk),
    .load   (in_acc),
    .map_en (state_r == ST_MAP),
    .item   (item),
    .cfg    (cfg),
    .cls    (cls)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign upd_go   = (state_r == ST_UPD) && out_free;
  assign is_add   = (cls.func == FN_ADD);

  // Sequence: clear pass, then accept, map, read, update
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_addr_r == ROW_W'(SOURCES - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_acc) state_nxt = ST_MAP;
      ST_MAP:   state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_UPD;
      ST_UPD:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + ROW_W'(1);
      end
    end
  end

  // Saturating increment of every hit sensor in the row
  always_comb begin
    for (int i = 0; i < SENSORS; i++) begin
      new_row[i*CNT_W +: CNT_W] = cls.hit[i] ? sat_inc(ram_rdata[i*CNT_W +: CNT_W])
                                             : ram_rdata[i*CNT_W +: CNT_W];
    end
  end

  // Count memory access: clear pass writes zero, an add with a hit writes the new row
  assign ram_re    = (state_r == ST_READ);
  assign ram_raddr = is_add ? cls.row : cls.source_sel[ROW_W-1:0];
  assign ram_we    = (state_r == ST_CLEAR) || (upd_go && is_add && (cls.hit != '0));
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_addr_r : cls.row;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : new_row;

  bhsh_ram #(
    .WIDTH (ROW_DATA_W),
    .DEPTH (SOURCES)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Advance the sensor totals on hits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SENSORS; i++) begin
        tot_r[i] <= '0;
      end
    end else if (upd_go && is_add) begin
      for (int i = 0; i < SENSORS; i++) begin
        if (cls.hit[i]) begin
          tot_r[i] <= sat_inc(tot_r[i]);
        end
      end
    end
  end

  // Select the read value
  always_comb begin
    rd_value = '0;
    case (cls.func)
      FN_RD_BIN: begin
        if ((int'(cls.sensor_sel) < SENSORS) && (int'(cls.source_sel) < SOURCES)) begin
          rd_value = ram_rdata[cls.sensor_sel*CNT_W +: CNT_W];
        end
      end
      FN_RD_TOT: begin
        if (int'(cls.sensor_sel) < SENSORS) begin
          rd_value = tot_r[cls.sensor_sel];
        end
      end
      default: rd_value = '0;
    endcase
  end

  // Output register: load on update, drop when the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_hit_r <= cls.hit;
      out_src_r <= cls.src_index;
      out_idv_r <= cls.id_valid;
      out_rd_r  <= rd_value;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hit_mask     = out_hit_r;
  assign out_ch.source_index = out_src_r;
  assign out_ch.id_valid     = out_idv_r;
  assign out_ch.read_value   = out_rd_r;

  // An accepted item passes the map and read steps, then reaches the update step
  a_acc_to_upd: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##3 (state_r == ST_UPD))
    else $error("accepted item did not reach the update step");

  // The count memory is never written and read in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !ram_re)
    else $error("count memory write overlaps a read");

  // A counted hit always comes with a valid bin
  a_hit_needs_bin: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.hit_mask == '0) || out_ch.id_valid))
    else $error("hit reported without a valid source bin");

  // No input is taken during the clearing pass
  a_no_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ch.ready)
    else $error("input ready during clearing pass");

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench: self-checking traffic and result checks for the box hit source histogram.
`timescale 1ns / 1ps
module tb_top
  import bhsh_pkg::*;
;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 6;
  localparam int IDLE_PCT     = 21;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 16;
  localparam int MAX_REPORTS  = 10;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 330;
  localparam int BURST_ITEMS  = 200;
  localparam longint COORD_MIN = -(longint'(1) << (COORD_W - 1));
  localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;
  localparam logic [CFG_W-1:0] SIZE_MAX = {3{{COORD_W{1'b1}}}};
  localparam logic [ID_W-1:0] ID_STEP = ID_W'(10000);

  // Indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [SENSORS-1:0] hit_mask;
    logic [SRC_W-1:0]   source_index;
    logic               id_valid;
    logic [CNT_W-1:0]   read_value;
  } result_t;

  logic clk;
  logic rst_n;

  bhsh_in_if  in_ch();
  bhsh_out_if out_ch();
  bhsh_cfg_if cfg_ch();

  box_hit_source_histogram_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Mirror of the registers and the counts
  logic [CFG_W-1:0]  center_q [NUM_CENTERS];
  logic [CFG_W-1:0]  box_q;
  logic [USED_W-1:0] used_q;
  logic [CNT_W-1:0]  bin_cnt_q [SENSORS][SOURCES];
  logic [CNT_W-1:0]  total_q [SENSORS];

  result_t pending_q [$];
  int      mismatches = 0;
  int      quiet_cycles = 0;
  bit      idle_en = 1'b1;

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // Predict one result and advance the mirrored counts
  function automatic result_t histogram_step(input item_t it);
    result_t r;
    longint bin, c, s, d;
    longint p [3];
    int n;
    bit in_box;
    logic signed [COORD_W-1:0] cs;
    r = '0;
    case (it.func)
      FN_ADD: begin
        bin = longint'(it.particle_id / ID_STEP) - 1;
        n = (used_q > SENSORS) ? SENSORS : int'(used_q);
        if (n > NUM_CENTERS) n = NUM_CENTERS;
        p[0] = it.pos_x;
        p[1] = it.pos_y;
        p[2] = it.pos_z;
        r.id_valid = (bin >= 0 && bin < SOURCES);
        if (r.id_valid) begin
          r.source_index = bin[SRC_W-1:0];
          for (int i = 0; i < n; i++) begin
            in_box = 1'b1;
            for (int k = 0; k < 3; k++) begin
              cs = center_q[i][COORD_W*k +: COORD_W];
              c = cs;
              s = longint'(box_q[COORD_W*k +: COORD_W]);
              d = 2 * (p[k] - c);
              if (d < -s || d > s) in_box = 1'b0;
            end
            if (in_box) begin
              bin_cnt_q[i][bin] = count_up(bin_cnt_q[i][bin]);
              total_q[i] = count_up(total_q[i]);
              r.hit_mask[i] = 1'b1;
            end
          end
        end
      end
      FN_RD_BIN: begin
        if (it.sensor_sel < SENSORS && it.source_sel < SOURCES)
          r.read_value = bin_cnt_q[it.sensor_sel][it.source_sel];
      end
      FN_RD_TOT: begin
        if (it.sensor_sel < SENSORS) r.read_value = total_q[it.sensor_sel];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] pack3(input longint x, input longint y, input longint z);
    return {z[COORD_W-1:0], y[COORD_W-1:0], x[COORD_W-1:0]};
  endfunction

  function automatic item_t add_item(input longint x, input longint y, input longint z,
                                     input logic [ID_W-1:0] id);
    item_t it;
    it = '0;
    it.func = FN_ADD;
    it.pos_x = x[COORD_W-1:0];
    it.pos_y = y[COORD_W-1:0];
    it.pos_z = z[COORD_W-1:0];
    it.particle_id = id;
    return it;
  endfunction

  function automatic item_t read_item(input func_t f, input int sel, input int src);
    item_t it;
    it = '0;
    it.func = f;
    it.sensor_sel = sel[SEL_W-1:0];
    it.source_sel = src[SRC_W-1:0];
    return it;
  endfunction

  // Coordinate around box i on axis k, a little past both faces
  function automatic longint near_coord(input int i, input int k);
    logic signed [COORD_W-1:0] cs;
    longint c, h;
    cs = center_q[i][COORD_W*k +: COORD_W];
    c = cs;
    h = longint'(box_q[COORD_W*k +: COORD_W]) / 2;
    return c + longint'($urandom_range(2 * h + 6)) - (h + 3);
  endfunction

  // Mostly a few low bins, so reads find nonzero counts
  function automatic int pick_bin();
    return ($urandom_range(3) == 0) ? $urandom_range(SOURCES - 1) : $urandom_range(7);
  endfunction

  function automatic item_t random_item();
    item_t it;
    int sel, i;
    sel = $urandom_range(99);
    i = $urandom_range(NUM_CENTERS - 1);
    if (sel < 55) begin
      it = add_item(near_coord(i, 0), near_coord(i, 1), near_coord(i, 2),
                    ID_W'((pick_bin() + 1) * 10000 + $urandom_range(9999)));
    end else if (sel < 62) begin
      it = add_item(near_coord(i, 0), near_coord(i, 1), near_coord(i, 2),
                    $urandom_range(1) ? ID_W'($urandom_range(9999))
                                      : ID_W'($urandom_range(16777215, 2570000)));
    end else if (sel < 70) begin
      it.func = func_t'($urandom_range(3));
      it.pos_x = COORD_W'($urandom);
      it.pos_y = COORD_W'($urandom);
      it.pos_z = COORD_W'($urandom);
      it.particle_id = ID_W'($urandom);
      it.sensor_sel = SEL_W'($urandom);
      it.source_sel = SRC_W'($urandom);
    end else if (sel < 85) begin
      it = read_item(FN_RD_BIN, $urandom_range(3), pick_bin());
    end else if (sel < 96) begin
      it = read_item(FN_RD_TOT, $urandom_range(3), $urandom_range(255));
    end else begin
      it = add_item($urandom, $urandom, $urandom, ID_W'($urandom));
      it.func = FN_NONE;
      it.sensor_sel = SEL_W'($urandom);
      it.source_sel = SRC_W'($urandom);
    end
    return it;
  endfunction

  // Send one item and queue its expected result once accepted
  task automatic send_item(input item_t it);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= it.func;
    in_ch.pos_x       <= it.pos_x;
    in_ch.pos_y       <= it.pos_y;
    in_ch.pos_z       <= it.pos_z;
    in_ch.particle_id <= it.particle_id;
    in_ch.sensor_sel  <= it.sensor_sel;
    in_ch.source_sel  <= it.source_sel;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_q.push_back(histogram_step(it));
  endtask

  // Hold off the sender until every expected result is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_CENTER_0, REG_CENTER_1, REG_CENTER_2, REG_CENTER_3: center_q[idx] = val;
      REG_BOX_SIZE:     box_q = val;
      REG_SENSORS_USED: used_q = val[USED_W-1:0];
      default: ;
    endcase
  endtask

  // Write every register, then release the channel
  task automatic configure(input logic [NUM_CENTERS-1:0][CFG_W-1:0] centers,
                           input logic [CFG_W-1:0] box, input logic [USED_W-1:0] used);
    write_reg(REG_CENTER_0, centers[0]);
    write_reg(REG_CENTER_1, centers[1]);
    write_reg(REG_CENTER_2, centers[2]);
    write_reg(REG_CENTER_3, centers[3]);
    write_reg(REG_BOX_SIZE, box);
    write_reg(REG_SENSORS_USED, CFG_W'(used));
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Reads after reset, spare function code, reset config on an empty box
  task automatic test_reset_state();
    item_t it;
    send_item(read_item(FN_RD_TOT, 0, 0));
    send_item(read_item(FN_RD_TOT, 3, 0));
    send_item(read_item(FN_RD_BIN, 3, 255));
    it = add_item(COORD_MAX, COORD_MIN, -1, {ID_W{1'b1}});
    it.func = FN_NONE;
    it.sensor_sel = '1;
    it.source_sel = '1;
    send_item(it);
    send_item(add_item(0, 0, 0, ID_STEP));
    drain();
  endtask

  // Inclusive faces, odd and even sizes, boxes at the coordinate extremes
  task automatic test_box_faces();
    configure({pack3(0, 0, 0), pack3(COORD_MAX, COORD_MAX, COORD_MAX),
               pack3(COORD_MIN, COORD_MIN, COORD_MIN), pack3(100, -200, 300)},
              pack3(2000, 2001, 64), USED_W'(4));
    send_item(add_item(1100, 800, 332, 24'd40000));
    send_item(add_item(-900, -1200, 268, 24'd40000));
    send_item(add_item(1101, -200, 300, 24'd40000));
    send_item(add_item(100, 801, 300, 24'd40000));
    send_item(add_item(100, -200, 333, 24'd40000));
    send_item(add_item(COORD_MIN, COORD_MIN, COORD_MIN, 24'd40000));
    send_item(add_item(COORD_MAX - 1000, COORD_MAX - 1000, COORD_MAX - 32, 24'd40000));
    send_item(read_item(FN_RD_TOT, 0, 0));
    send_item(read_item(FN_RD_BIN, 2, 3));
    drain();
  endtask

  // Identifier to bin edges under a box that covers nearly everything
  task automatic test_id_mapping();
    configure('0, SIZE_MAX, USED_W'(4));
    send_item(add_item(COORD_MIN, 0, 0, 24'd10000));
    send_item(add_item(COORD_MAX, COORD_MAX, COORD_MAX, 24'd0));
    send_item(add_item(-COORD_MAX, -COORD_MAX, -COORD_MAX, 24'd9999));
    send_item(add_item(1, 2, 3, 24'd2569999));
    send_item(add_item(1, 2, 3, 24'd2570000));
    send_item(add_item(1, 2, 3, {ID_W{1'b1}}));
    send_item(read_item(FN_RD_BIN, 3, 255));
    drain();
  endtask

  // Zero, one and more than the available sensors enabled
  task automatic test_sensor_enable();
    configure('0, SIZE_MAX, USED_W'(0));
    send_item(add_item(0, 0, 0, 24'd10000));
    drain();
    configure('0, SIZE_MAX, USED_W'(1));
    send_item(add_item(0, 0, 0, 24'd10000));
    drain();
    configure('0, SIZE_MAX, USED_W'(7));
    send_item(add_item(0, 0, 0, 24'd10000));
    send_item(read_item(FN_RD_TOT, 1, 0));
    drain();
  endtask

  // Random traffic over a series of register settings
  task automatic test_random_traffic();
    logic [NUM_CENTERS-1:0][CFG_W-1:0] centers;
    logic [CFG_W-1:0] box;
    logic [USED_W-1:0] used;
    for (int ph = 0; ph < PHASES; ph++) begin
      foreach (centers[i])
        centers[i] = pack3(longint'($urandom_range(8000)) - 4000,
                           longint'($urandom_range(8000)) - 4000,
                           longint'($urandom_range(8000)) - 4000);
      box = pack3($urandom_range(8000), $urandom_range(8000), $urandom_range(8000));
      case (ph)
        0: used = USED_W'(4);
        1: used = USED_W'(1);
        2: begin
          foreach (centers[i]) centers[i] = CFG_W'({$urandom, $urandom});
          box = CFG_W'({$urandom, $urandom});
          used = USED_W'(7);
          write_reg(REG_SPARE_LO, CFG_W'({$urandom, $urandom}));
          write_reg(REG_SPARE_HI, '1);
        end
        3: used = USED_W'(2);
        default: begin
          centers[0] = pack3(COORD_MIN + 1000, COORD_MIN + 1000, COORD_MIN + 1000);
          centers[1] = pack3(COORD_MAX - 1000, COORD_MAX - 1000, COORD_MAX - 1000);
          centers[2] = pack3(COORD_MIN, COORD_MAX, 0);
          box = pack3($urandom_range(2097151, 1500000), $urandom_range(2097151, 1500000),
                      $urandom_range(2097151, 1500000));
          used = USED_W'(4);
        end
      endcase
      configure(centers, box, used);
      repeat (PHASE_ITEMS) send_item(random_item());
      drain();
    end
  endtask

  // Back-to-back stretch with both sides always willing
  task automatic test_no_idle_burst();
    configure({pack3(0, 0, 0), pack3(500, 500, 500), pack3(-500, 0, 500), pack3(0, -500, 0)},
              pack3(3000, 3000, 3000), USED_W'(4));
    idle_en = 1'b0;
    repeat (BURST_ITEMS) send_item(random_item());
    drain();
    idle_en = 1'b1;
  endtask

  // Receiver ready, stalling at random
  always @(posedge clk) begin
    out_ch.ready <= !idle_en || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.hit_mask     = out_ch.hit_mask;
      got.source_index = out_ch.source_index;
      got.id_valid     = out_ch.id_valid;
      got.read_value   = out_ch.read_value;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: hit=%h src=%0d valid=%b value=%0d",
                   got.hit_mask, got.source_index, got.id_valid, got.read_value);
      end else begin
        want = pending_q.pop_front();
        if (got.hit_mask !== want.hit_mask || got.source_index !== want.source_index ||
            got.id_valid !== want.id_valid || got.read_value !== want.read_value) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: exp hit=%h src=%0d v=%b val=%0d got hit=%h src=%0d v=%b val=%0d",
                     want.hit_mask, want.source_index, want.id_valid, want.read_value,
                     got.hit_mask, got.source_index, got.id_valid, got.read_value);
        end
      end
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.func        = '0;
    in_ch.pos_x       = '0;
    in_ch.pos_y       = '0;
    in_ch.pos_z       = '0;
    in_ch.particle_id = '0;
    in_ch.sensor_sel  = '0;
    in_ch.source_sel  = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    foreach (center_q[i]) center_q[i] = '0;
    box_q = '0;
    used_q = USED_RESET;
    foreach (bin_cnt_q[i, j]) bin_cnt_q[i][j] = '0;
    foreach (total_q[i]) total_q[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_box_faces();
    test_id_mapping();
    test_sensor_enable();
    test_random_traffic();
    test_no_idle_burst();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
